>>> rtl/jsu_pkg.sv
// ============================================================================
// jsu_pkg: shared types and constants for the JSON string unescaper
// Escape phase codes, the run record passed from front to back and the
// queue sizing.
// ============================================================================
package jsu_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_ESCAPE = 3'd1,
        PH_HEX0   = 3'd2,
        PH_HEX1   = 3'd3,
        PH_HEX2   = 3'd4,
        PH_HEX3   = 3'd5
    } phase_t;

    // One run: the 1 to 3 output bytes caused by one input byte
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      cnt;
        logic            last;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> rtl/jsu_front.sv
// ============================================================================
// jsu_front: escape decoder
// Tracks the escape state per input byte and builds one run record of
// decoded bytes, pushed into the run queue when the byte yields output.
// ============================================================================
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    output logic       run_push,
    output run_t       run
);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;

    phase_t      phase_reg, phase_next;
    logic [11:0] hex_reg, hex_next;
    logic [3:0]  digit;
    logic [15:0] cp;
    logic        run_valid;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    assign digit = hex_value(in_byte);
    assign cp    = {hex_reg, digit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            hex_reg   <= 12'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_ESCAPE:
                begin
                    phase_next = PH_NORMAL;
                    if (in_byte == CH_U)
                    begin
                        phase_next = PH_HEX0;
                        hex_next   = 12'd0;
                    end
                end
                PH_HEX0:
                begin
                    phase_next = PH_HEX1;
                    hex_next   = {hex_reg[7:0], digit};
                end
                PH_HEX1:
                begin
                    phase_next = PH_HEX2;
                    hex_next   = {hex_reg[7:0], digit};
                end
                PH_HEX2:
                begin
                    phase_next = PH_HEX3;
                    hex_next   = {hex_reg[7:0], digit};
                end
                PH_HEX3:
                begin
                    phase_next = PH_NORMAL;
                    hex_next   = 12'd0;
                end
                default:
                begin
                    phase_next = (in_byte == CH_BSLASH) ? PH_ESCAPE : PH_NORMAL;
                end
            endcase
            if (string_last)
            begin
                phase_next = PH_NORMAL;
                hex_next   = 12'd0;
            end
        end
    end

    // run record
    always_comb
    begin
        run_valid = 1'b1;
        run.data  = '0;
        run.cnt   = 2'd1;
        run.last  = string_last;
        unique case (phase_reg)
            PH_ESCAPE:
            begin
                unique case (in_byte)
                    CH_N:      run.data[0] = 8'h0A;
                    CH_R:      run.data[0] = 8'h0D;
                    CH_B:      run.data[0] = 8'h08;
                    CH_T:      run.data[0] = 8'h09;
                    CH_F:      run.data[0] = 8'h0C;
                    CH_BSLASH: run.data[0] = CH_BSLASH;
                    CH_QUOTE:  run.data[0] = CH_QUOTE;
                    CH_U:
                    begin
                        run.data[0] = CH_QMARK;
                        run_valid   = string_last;
                    end
                    default:   run.data[0] = CH_QMARK;
                endcase
            end
            PH_HEX0, PH_HEX1, PH_HEX2:
            begin
                run.data[0] = CH_QMARK;
                run_valid   = string_last;
            end
            PH_HEX3:
            begin
                if (cp < 16'h0080)
                begin
                    run.data[0] = cp[7:0];
                end
                else if (cp < 16'h0800)
                begin
                    run.data[0] = 8'hC0 | {3'd0, cp[10:6]};
                    run.data[1] = 8'h80 | {2'd0, cp[5:0]};
                    run.cnt     = 2'd2;
                end
                else
                begin
                    run.data[0] = 8'hE0 | {4'd0, cp[15:12]};
                    run.data[1] = 8'h80 | {2'd0, cp[11:6]};
                    run.data[2] = 8'h80 | {2'd0, cp[5:0]};
                    run.cnt     = 2'd3;
                end
            end
            default:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    run.data[0] = CH_QMARK;
                    run_valid   = string_last;
                end
                else
                begin
                    run.data[0] = in_byte;
                end
            end
        endcase
    end

    assign run_push = accept && run_valid;

endmodule

>>> rtl/jsu_queue.sv
// ============================================================================
// jsu_queue: run queue
// Small FIFO of run records between the decoder and the serializer.
// ============================================================================
module jsu_queue
    import jsu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  run_t   wr_run,
    input  logic   pop,
    output run_t   rd_run,
    output qstat_t stat
);

    run_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_run     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QAW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/jsu_back.sv
// ============================================================================
// jsu_back: byte serializer
// Walks the head run one byte per cycle into the output reg unless stalled.
// ============================================================================
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  run_t       head,
    input  qstat_t     qstat,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] byte_reg;
    logic       run_last_reg, string_end_reg;
    logic       load, fin;

    assign load  = !qstat.empty && (!valid_reg || pop);
    assign fin   = (idx_reg == head.cnt - 2'd1);
    assign q_pop = load && fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= fin ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg       <= head.data[idx_reg];
            run_last_reg   <= fin;
            string_end_reg <= fin && head.last;
        end
    end

    assign empty      = !valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = string_end_reg;

endmodule

>>> rtl/json_string_unescape_utf8.sv
// ============================================================================
// json_string_unescape_utf8: JSON string body unescaper with UTF-8 output
// Decodes escapes and \u sequences of a byte stream into unescaped bytes.
// ============================================================================
// Usage:
//   Input queue side: drive in_byte/string_last with push; a transfer takes
//   place on a clock edge with push high and full low.
//   Result side: while empty is low the oldest result is on out_byte,
//   run_last and string_end; it transfers on an edge with pop high.
//   Throughput: one input byte per cycle in while full is low, one result
//   byte per cycle out while pop is high. A \u escape yields up to 3 bytes but
//   consumes 6 input bytes, so output normally keeps up; bursts are absorbed
//   by a 4-run queue. A result goes through the run queue into the output
//   register and is held there until popped. Opening backslashes, 'u' and the
//   first three hex digits produce no result unless string_last is set.
//   When the receiver stalls, the queue fills and full rises; no data lost.
//   Reset (rst_n low, asynchronous) returns the escape state to normal and
//   empties the queue and output register.
// ============================================================================
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    qstat_t qstat;
    run_t   wr_run, head;
    logic   q_push, q_pop, accept;

    assign full   = qstat.full;
    assign accept = push && !qstat.full;

    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .string_last (string_last),
        .run_push    (q_push),
        .run         (wr_run)
    );

    jsu_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_run (wr_run),
        .pop    (q_pop),
        .rd_run (head),
        .stat   (qstat)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

`ifndef ASSERT_OFF
    a_qstat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && qstat.empty) |=> !qstat.empty)
        else $error("run pushed to empty queue was lost");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty)
        else $error("serializer popped an empty queue");

    a_push_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !qstat.full)
        else $error("run pushed while queue full");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: JSON string unescaper with UTF-8 output
// Sends plain bytes, simple escapes, \u escapes and cut-off escapes through
// the push/full side and checks every popped byte against a predictor of the
// unescape state machine, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench
    import jsu_pkg::*;
();

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_G   = 8'h67;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_FF      = 8'h0C;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } out_rec_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       string_last;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    // predictor state
    phase_t      esc_phase;
    logic [11:0] hex_acc;

    out_rec_t   pending_unescaped[$];
    out_rec_t   popped_rec;
    logic [7:0] txt[$];
    int         error_count;
    int         send_idle_pct;
    int         recv_idle_pct;

    json_string_unescape_utf8 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .string_last (string_last),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_end  (string_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        if (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9)
            return 4'(c - CH_DIGIT0);
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5)
            return 4'(c - CH_LOWER_A + 8'd10);
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5)
            return 4'(c - CH_UPPER_A + 8'd10);
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 4'd10)
            return CH_DIGIT0 + 8'(v);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
    endfunction

    // Advance the unescape state by one input byte and queue its output run
    function automatic void predict_unescape(logic [7:0] c, logic lst);
        logic [7:0] run [3];
        int         n;
        logic [3:0] d;
        logic [15:0] cp;
        out_rec_t   rec;
        n = 0;
        d = hex_nibble(c);
        if (esc_phase == PH_ESCAPE)
        begin
            esc_phase = PH_NORMAL;
            n = 1;
            case (c)
                CH_LOW_N:           run[0] = CH_LF;
                CH_LOW_R:           run[0] = CH_CR;
                CH_LOW_B:           run[0] = CH_BS;
                CH_LOW_T:           run[0] = CH_TAB;
                CH_LOW_F:           run[0] = CH_FF;
                CH_BSLASH, CH_QUOTE: run[0] = c;
                CH_LOW_U:
                begin
                    if (lst)
                        run[0] = CH_QMARK;
                    else
                    begin
                        esc_phase = PH_HEX0;
                        hex_acc   = '0;
                        n         = 0;
                    end
                end
                default:            run[0] = CH_QMARK;
            endcase
        end
        else if (esc_phase >= PH_HEX0 && esc_phase <= PH_HEX3)
        begin
            if (esc_phase == PH_HEX3)
            begin
                cp        = {hex_acc, d};
                esc_phase = PH_NORMAL;
                hex_acc   = '0;
                if (cp < 16'h0080)
                begin
                    run[0] = cp[7:0];
                    n      = 1;
                end
                else if (cp < 16'h0800)
                begin
                    run[0] = 8'hC0 + 8'(cp[10:6]);
                    run[1] = 8'h80 + 8'(cp[5:0]);
                    n      = 2;
                end
                else
                begin
                    run[0] = 8'hE0 + 8'(cp[15:12]);
                    run[1] = 8'h80 + 8'(cp[11:6]);
                    run[2] = 8'h80 + 8'(cp[5:0]);
                    n      = 3;
                end
            end
            else if (lst)
            begin
                esc_phase = PH_NORMAL;
                hex_acc   = '0;
                run[0]    = CH_QMARK;
                n         = 1;
            end
            else
            begin
                hex_acc   = {hex_acc[7:0], d};
                esc_phase = phase_t'(esc_phase + 3'd1);
            end
        end
        else
        begin
            // normal; stray phase codes behave the same way
            esc_phase = PH_NORMAL;
            if (c == CH_BSLASH)
            begin
                if (lst)
                begin
                    run[0] = CH_QMARK;
                    n      = 1;
                end
                else
                    esc_phase = PH_ESCAPE;
            end
            else
            begin
                run[0] = c;
                n      = 1;
            end
        end
        if (lst)
        begin
            esc_phase = PH_NORMAL;
            hex_acc   = '0;
        end
        for (int k = 0; k < n; k++)
        begin
            rec.data       = run[k];
            rec.run_last   = (k == n - 1);
            rec.string_end = (k == n - 1) && lst;
            pending_unescaped.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: mismatch on %s: got 0x%02h, expected 0x%02h",
                 $time, what, got, want);
        error_count++;
    endtask

    // One transfer on the input side; push stays high between back-to-back items
    task automatic send_item(input logic [7:0] b, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        in_byte     <= b;
        string_last <= lst;
        do
            @(posedge clk);
        while (full);
        predict_unescape(b, lst);
    endtask

    task automatic flush_text(input logic end_string);
        foreach (txt[i])
            send_item(txt[i], end_string && (i == txt.size() - 1));
        txt.delete();
    endtask

    task automatic add_unicode(input logic [15:0] cp, input bit allow_junk);
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_LOW_U);
        for (int i = 3; i >= 0; i--)
        begin
            if (allow_junk && $urandom_range(0, 11) == 0)
                txt.push_back(8'($urandom_range(CH_LOW_G, CH_LOW_Z)));
            else
                txt.push_back(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
        end
    endtask

    always @(posedge clk)
    begin
        pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result checker: pop and empty are sampled as they were at the edge
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_unescaped.size() == 0)
                report_mismatch("unexpected result", out_byte, 8'h00);
            else
            begin
                popped_rec = pending_unescaped.pop_front();
                if (out_byte !== popped_rec.data)
                    report_mismatch("out_byte", out_byte, popped_rec.data);
                if (run_last !== popped_rec.run_last)
                    report_mismatch("run_last", 8'(run_last), 8'(popped_rec.run_last));
                if (string_end !== popped_rec.string_end)
                    report_mismatch("string_end", 8'(string_end),
                                    8'(popped_rec.string_end));
            end
        end
    end

    task automatic test_plain_bytes();
        txt.push_back(8'hFF);
        flush_text(1'b0);
        txt.push_back(8'h00);
        flush_text(1'b1);
    endtask

    task automatic test_simple_escapes();
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_LOW_N);
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_LOW_Z);
        flush_text(1'b0);
    endtask

    task automatic test_unicode_escapes();
        add_unicode(16'hFFFF, 1'b0);
        // non-hex digit counts as zero: \u07Fz gives 0x07F0
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_LOW_U);
        txt.push_back(CH_DIGIT0);
        txt.push_back(CH_DIGIT0 + 8'd7);
        txt.push_back(CH_UPPER_A + 8'd5);
        txt.push_back(CH_LOW_Z);
        add_unicode(16'h0000, 1'b0);
        flush_text(1'b1);
    endtask

    task automatic test_incomplete_escapes();
        txt.push_back(CH_BSLASH);
        flush_text(1'b1);
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_LOW_U);
        flush_text(1'b1);
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_LOW_U);
        txt.push_back(CH_DIGIT0 + 8'd1);
        flush_text(1'b1);
    endtask

    // Mostly well-formed strings with random content, plus cut-off escapes
    task automatic test_random_strings(input int n_items, input int snd_pct,
                                       input int rcv_pct);
        int          sent;
        int          ntok;
        int          kind;
        logic [15:0] cp;
        logic [7:0]  b;
        sent          = 0;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        while (sent < n_items)
        begin
            ntok = $urandom_range(1, 8);
            for (int t = 0; t < ntok; t++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 35)
                begin
                    b = 8'($urandom_range(1, 255));
                    if ($urandom_range(0, 49) == 0)
                        b = 8'h00;
                    txt.push_back(b);
                end
                else if (kind < 55)
                begin
                    txt.push_back(CH_BSLASH);
                    case ($urandom_range(0, 6))
                        0:       txt.push_back(CH_LOW_N);
                        1:       txt.push_back(CH_LOW_R);
                        2:       txt.push_back(CH_LOW_B);
                        3:       txt.push_back(CH_LOW_T);
                        4:       txt.push_back(CH_LOW_F);
                        5:       txt.push_back(CH_BSLASH);
                        default: txt.push_back(CH_QUOTE);
                    endcase
                end
                else if (kind < 62)
                begin
                    txt.push_back(CH_BSLASH);
                    txt.push_back(8'($urandom_range(1, 255)));
                end
                else if (kind < 87)
                begin
                    case ($urandom_range(0, 2))
                        0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    endcase
                    add_unicode(cp, 1'b1);
                end
                else if (kind < 93)
                begin
                    // \u cut short; the following bytes get eaten as digits
                    txt.push_back(CH_BSLASH);
                    txt.push_back(CH_LOW_U);
                    repeat ($urandom_range(0, 3))
                        txt.push_back(hex_char(4'($urandom_range(0, 15)),
                                               1'($urandom_range(0, 1))));
                end
                else
                    txt.push_back(CH_BSLASH);
            end
            sent += txt.size();
            flush_text(1'b1);
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        in_byte       = 8'h00;
        string_last   = 1'b0;
        error_count   = 0;
        esc_phase     = PH_NORMAL;
        hex_acc       = '0;
        send_idle_pct = 30;
        recv_idle_pct = 55;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_simple_escapes();
        test_unicode_escapes();
        test_incomplete_escapes();
        test_random_strings(135, 30, 55);
        test_random_strings(135, 55, 30);
        test_random_strings(135, 0, 0);

        push <= 1'b0;
        while (pending_unescaped.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
verif/testbench.sv
